// ===== src/relvs_pkg.sv =====
// Shared types and constants of the rank-excluding LRU victim selector.
package relvs_pkg;

   typedef enum logic [1:0] {
      OP_TOUCH      = 2'd0,
      OP_INSERT     = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_VICTIM     = 2'd3
   } op_type;

   typedef logic [2:0]  rank_type;
   typedef logic [47:0] tick_type;
   typedef logic [1:0]  phase_type;

   localparam rank_type RANK_INVALID = 3'd4;

   // Estimate now / 10000000 as the top 24 bits of the time times floor(2^48 / 10000000),
   // shifted down by 24. The estimate never exceeds the true quotient and falls short by
   // at most 3, so the remainder against it stays below 40000000.
   typedef logic [24:0] quot_type;
   localparam quot_type PHASE_RECIP     = 25'd28147497;
   localparam quot_type TICKS_PER_PHASE = 25'd10000000;

   typedef logic [25:0] span_type;
   localparam span_type PHASE_1_START = 26'd10000000;
   localparam span_type PHASE_2_START = 26'd20000000;
   localparam span_type PHASE_3_START = 26'd30000000;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL_HI = 5'b00010,
      ST_MUL_LO = 5'b00100,
      ST_PHASE  = 5'b01000,
      ST_SCAN   = 5'b10000
   } state_type;

endpackage

// ===== src/rank_excluding_lru_victim_select_core.sv =====
// Top level: per-set rank and last-touch store with a sequenced victim scan.
//
// Replacement state for one cache set of WAYS ways. Touch, insert and invalidate
// return a zero result on the next cycle. A victim request runs as a sequence and
// repeats its scan as plain LRU when every way holds a special rank: two passes
// through one shared 25 x 25 multiplier reduce the time to its phase (a reciprocal
// estimate of the quotient, then the remainder against that estimate), ST_PHASE
// decodes the phase, and then a single 48-bit comparator visits the ways one per
// cycle, stopping early at the first invalid way. The block takes no request while
// a victim scan runs or while a stalled result occupies the output register.
module rank_excluding_lru_victim_select_core #(
   parameter int WAYS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // way [2:0], address [50:3], now [98:51], zero fill
   input  logic [1:0]   req_tuser,   // operation [1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // victim_way [2:0], zero fill
   output logic         rsp_tuser    // victim_valid [0]
);

   localparam int WIDX = $clog2(WAYS);
   localparam int XW   = (WIDX > 3) ? WIDX : 3;

   typedef logic [WIDX-1:0] idx_type;

   // request fields
   relvs_pkg::op_type   req_op;
   logic [2:0]          req_way;
   relvs_pkg::tick_type req_address;
   relvs_pkg::tick_type req_now;

   assign req_op      = relvs_pkg::op_type'(req_tuser);
   assign req_way     = req_tdata[2:0];
   assign req_address = req_tdata[50:3];
   assign req_now     = req_tdata[98:51];

   // per-way state
   relvs_pkg::rank_type rank_ff [WAYS];
   relvs_pkg::tick_type time_ff [WAYS];

   // sequencer and datapath registers
   relvs_pkg::state_type   state_ff, state_in;
   relvs_pkg::tick_type    now_ff, now_in;
   relvs_pkg::quot_type    quot_ff, quot_in;
   relvs_pkg::span_type    span_ff, span_in;
   relvs_pkg::phase_type   phase_ff, phase_in;
   idx_type                idx_ff, idx_in;
   idx_type                best_ff, best_in;
   relvs_pkg::tick_type    best_time_ff, best_time_in;
   logic                   have_ff, have_in;
   logic                   fallback_ff, fallback_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_way_ff, rsp_way_in;
   logic                   rsp_flag_ff, rsp_flag_in;

   logic                   accept;
   logic                   wr_en;
   logic [XW-1:0]          way_ext;
   idx_type                wr_idx;
   relvs_pkg::rank_type    wr_rank;
   relvs_pkg::tick_type    wr_time;

   relvs_pkg::quot_type    mul_a;
   relvs_pkg::quot_type    mul_b;
   logic [48:0]            mul_p;
   relvs_pkg::phase_type   phase_next;
   relvs_pkg::phase_type   phase_succ;

   relvs_pkg::rank_type    scan_rank;
   relvs_pkg::tick_type    scan_time;
   logic                   scan_special;
   logic                   scan_invalid;
   logic                   scan_take;
   logic                   scan_last;
   idx_type                best_next;
   logic                   have_next;

   assign req_tready = (state_ff == relvs_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // state writes: drop way numbers beyond the set
   assign way_ext = XW'(req_way);
   assign wr_idx  = way_ext[WIDX-1:0];
   assign wr_en   = accept && (req_op != relvs_pkg::OP_VICTIM) && (32'(way_ext) < 32'(WAYS));
   assign wr_rank = (req_op == relvs_pkg::OP_INVALIDATE) ? relvs_pkg::RANK_INVALID
                                                          : {1'b0, req_address[18], req_address[6]};
   assign wr_time = (req_op == relvs_pkg::OP_INVALIDATE) ? '0 : req_now;

   // shared multiplier: quotient estimate first, then estimate times 10000000
   assign mul_a = (state_ff == relvs_pkg::ST_MUL_HI) ? {1'b0, now_ff[47:24]} : quot_ff;
   assign mul_b = (state_ff == relvs_pkg::ST_MUL_HI) ? relvs_pkg::PHASE_RECIP
                                                     : relvs_pkg::TICKS_PER_PHASE;
   assign mul_p = 49'(mul_a) * 49'(mul_b);

   // which quarter of 40000000 the remainder falls in corrects the estimate
   always_comb begin
      priority if (span_ff >= relvs_pkg::PHASE_3_START) begin
         phase_next = 2'd3;
      end else if (span_ff >= relvs_pkg::PHASE_2_START) begin
         phase_next = 2'd2;
      end else if (span_ff >= relvs_pkg::PHASE_1_START) begin
         phase_next = 2'd1;
      end else begin
         phase_next = 2'd0;
      end
   end

   assign phase_succ = phase_ff + 2'd1;

   // scan step over the way at idx_ff
   assign scan_rank    = rank_ff[idx_ff];
   assign scan_time    = time_ff[idx_ff];
   assign scan_special = !fallback_ff && ((scan_rank == {1'b0, phase_ff}) ||
                                          (scan_rank == {1'b0, phase_succ}));
   assign scan_invalid = !scan_special && (scan_rank == relvs_pkg::RANK_INVALID);
   assign scan_take    = !scan_special && !scan_invalid &&
                         (!have_ff || (scan_time < best_time_ff));
   assign scan_last    = (idx_ff == idx_type'(WAYS - 1));
   assign best_next    = scan_take ? idx_ff : best_ff;
   assign have_next    = have_ff || scan_take;

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      quot_in      = quot_ff;
      span_in      = span_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_time_in = best_time_ff;
      have_in      = have_ff;
      fallback_in  = fallback_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_way_in   = rsp_way_ff;
      rsp_flag_in  = rsp_flag_ff;

      unique case (state_ff)
         relvs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == relvs_pkg::OP_VICTIM) begin
                  state_in = relvs_pkg::ST_MUL_HI;
                  now_in   = req_now;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_way_in   = '0;
                  rsp_flag_in  = 1'b0;
               end
            end
         end
         relvs_pkg::ST_MUL_HI: begin
            quot_in  = mul_p[48:24];
            state_in = relvs_pkg::ST_MUL_LO;
         end
         relvs_pkg::ST_MUL_LO: begin
            span_in  = now_ff[25:0] - mul_p[25:0];
            state_in = relvs_pkg::ST_PHASE;
         end
         relvs_pkg::ST_PHASE: begin
            phase_in    = quot_ff[1:0] + phase_next;
            idx_in      = '0;
            have_in     = 1'b0;
            fallback_in = 1'b0;
            state_in    = relvs_pkg::ST_SCAN;
         end
         relvs_pkg::ST_SCAN: begin
            priority if (scan_invalid) begin
               state_in     = relvs_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_way_in   = 3'(idx_ff);
               rsp_flag_in  = 1'b1;
            end else if (scan_last && have_next) begin
               state_in     = relvs_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_way_in   = 3'(best_next);
               rsp_flag_in  = 1'b1;
            end else if (scan_last) begin
               // every way special: rerun as plain LRU
               fallback_in = 1'b1;
               have_in     = 1'b0;
               idx_in      = '0;
            end else begin
               idx_in       = idx_ff + idx_type'(1);
               best_in      = best_next;
               best_time_in = scan_take ? scan_time : best_time_ff;
               have_in      = have_next;
            end
         end
         default: begin
            state_in = relvs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= relvs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      quot_ff      <= quot_in;
      span_ff      <= span_in;
      phase_ff     <= phase_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_time_ff <= best_time_in;
      have_ff      <= have_in;
      fallback_ff  <= fallback_in;
      rsp_way_ff   <= rsp_way_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WAYS; i++) begin
            rank_ff[i] <= relvs_pkg::RANK_INVALID;
         end
      end else if (wr_en) begin
         rank_ff[wr_idx] <= wr_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_ff[wr_idx] <= wr_time;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_way_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule

// ===== src/relvs_checker.sv =====
// Port-level checker for the victim selector and its bind to the top level.
module relvs_checker #(
   parameter int WAYS = 8
) (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // state updates answer with an empty result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != relvs_pkg::OP_VICTIM)
      |=> rsp_tvalid && !rsp_tuser && (rsp_tdata == 8'd0))
      else $error("update transfer without its empty result");

   // a victim request occupies the block and cannot answer at once
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == relvs_pkg::OP_VICTIM)
      |=> !rsp_tvalid && !req_tready)
      else $error("victim request answered or overlapped too early");

   // a victim lies inside the set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser
      |-> (rsp_tdata[7:3] == 5'd0) && ((WAYS > 8) || (32'(rsp_tdata[2:0]) < WAYS)))
      else $error("victim outside the set");

endmodule

bind rank_excluding_lru_victim_select_core relvs_checker #(.WAYS(WAYS)) u_relvs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
